// ----- sv/lsb_stego_pkg.sv -----
// Package with the word types, register indexes and constants of the LSB BMP stego block.
`default_nettype none
package lsb_stego_pkg;

  localparam int MaxImageWidth = 16384;
  localparam int RowBytesW     = 16;
  localparam int CfgIndexW     = 2;
  localparam int CfgDataW      = 32;

  localparam logic [CfgIndexW-1:0] CFG_MODE           = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_RECOVER = 1'b1;

  localparam logic CMD_FILE_BYTE    = 1'b0;
  localparam logic CMD_PAYLOAD_BYTE = 1'b1;

  // Header byte positions.
  localparam logic [31:0] PosLenFirst = 32'd6;
  localparam logic [31:0] PosLenLast  = 32'd9;
  localparam logic [31:0] PosOffFirst = 32'd10;
  localparam logic [31:0] PosOffLast  = 32'd13;
  localparam logic [31:0] PosPixFirst = 32'd14;

  localparam logic [7:0] LsbClearMask = 8'hFE;

  typedef struct packed {
    logic       command;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_missing;
    logic       finished;
  } out_word_t;

  // Row length in bytes for a configured width, with zero read as one and
  // large widths saturated.
  function automatic logic [RowBytesW-1:0] row_bytes_f(input logic [14:0] width);
    logic [RowBytesW-1:0] w;
    begin
      w = RowBytesW'(width);
      if (w == '0) begin
        w = RowBytesW'(1);
      end else if (w > RowBytesW'(MaxImageWidth)) begin
        w = RowBytesW'(MaxImageWidth);
      end
      row_bytes_f = w + (w << 1);
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/lsb_stego_bmp_embed_extract_top.sv -----
// Top level of the LSB steganography block for streamed 24-bit BMP files.
`default_nettype none
// Streams a 24-bit BMP file one byte per input word and either hides payload
// bits in the least significant bits of the pixel bytes (mode 0) or rebuilds the
// hidden bytes (mode 1). Payload bytes to hide enter on the same channel with
// command set. The block takes one word per cycle unless output stalls it: all the
// per-word work is one counter update and one bit replacement, done in the cycle
// the word is accepted, and any result appears in the output register on the
// next cycle. A word that gives no result (payload bytes, and in recover mode
// header, padding and most pixel bytes) is still consumed. Input stalls only
// while the output register holds a word that the consumer does not take.
// The user writes configuration only while the block is idle; it is not enforced.
module lsb_stego_bmp_embed_extract_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lsb_stego_pkg::in_word_t           in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output lsb_stego_pkg::out_word_t               out_data,
  input  wire logic                              cfg_we,
  input  wire logic [lsb_stego_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [lsb_stego_pkg::CfgDataW-1:0]  cfg_data
);
  import lsb_stego_pkg::*;

  // Configuration
  logic                 mode_r;
  logic [RowBytesW-1:0] row_bytes_r;
  logic [1:0]           pad_len_r;
  logic [31:0]          payload_length_r;

  // Stream state
  logic [31:0]          file_position_r, file_position_nxt;
  logic [31:0]          pixel_offset_r, pixel_offset_nxt;
  logic [31:0]          header_length_r, header_length_nxt;
  logic [RowBytesW-1:0] row_byte_count_r, row_byte_count_nxt;
  logic [1:0]           padding_left_r, padding_left_nxt;
  logic [2:0]           bit_index_r, bit_index_nxt;
  logic [7:0]           payload_shift_r, payload_shift_nxt;
  logic                 payload_loaded_r, payload_loaded_nxt;
  logic [31:0]          bytes_done_r, bytes_done_nxt;
  logic [7:0]           assembled_byte_r, assembled_byte_nxt;

  logic                 out_valid_r;
  out_word_t            out_data_r, result;
  logic                 emit;
  logic                 accept;

  logic [1:0]           lane;
  logic [31:0]          done_inc;
  logic [RowBytesW:0]   row_inc;
  logic [RowBytesW-1:0] rb_now;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lane     = 2'(file_position_r[1:0] - 2'd2);
  assign done_inc = bytes_done_r + 32'd1;
  assign row_inc  = {1'b0, row_byte_count_r} + (RowBytesW+1)'(1);
  assign rb_now   = row_bytes_r;

  always_comb begin
    file_position_nxt  = file_position_r;
    pixel_offset_nxt   = pixel_offset_r;
    header_length_nxt  = header_length_r;
    row_byte_count_nxt = row_byte_count_r;
    padding_left_nxt   = padding_left_r;
    bit_index_nxt      = bit_index_r;
    payload_shift_nxt  = payload_shift_r;
    payload_loaded_nxt = payload_loaded_r;
    bytes_done_nxt     = bytes_done_r;
    assembled_byte_nxt = assembled_byte_r;
    result.out_byte        = in_data.value;
    result.payload_missing = 1'b0;
    result.finished        = 1'b0;
    emit = 1'b0;

    if (in_data.command == CMD_PAYLOAD_BYTE) begin
      if (mode_r == MODE_EMBED && !payload_loaded_r && bytes_done_r < payload_length_r) begin
        payload_shift_nxt  = in_data.value;
        payload_loaded_nxt = 1'b1;
        bit_index_nxt      = 3'd7;
      end
    end else begin
      emit = (mode_r == MODE_EMBED);
      if (file_position_r != '1) begin
        file_position_nxt = file_position_r + 32'd1;
      end

      if (file_position_r >= PosLenFirst && file_position_r <= PosLenLast) begin
        header_length_nxt[lane*8 +: 8] = in_data.value;
        if (mode_r == MODE_EMBED) begin
          result.out_byte = payload_length_r[lane*8 +: 8];
        end
      end else if (file_position_r >= PosOffFirst && file_position_r <= PosOffLast) begin
        pixel_offset_nxt[lane*8 +: 8] = in_data.value;
      end else if (file_position_r >= PosPixFirst && file_position_r >= pixel_offset_r) begin
        if (padding_left_r != 2'd0) begin
          padding_left_nxt = padding_left_r - 2'd1;
        end else begin
          if (mode_r == MODE_EMBED) begin
            if (bytes_done_r < payload_length_r) begin
              if (payload_loaded_r) begin
                result.out_byte = (in_data.value & LsbClearMask) |
                                  {7'd0, payload_shift_r[bit_index_r]};
                if (bit_index_r == 3'd0) begin
                  payload_loaded_nxt = 1'b0;
                  bit_index_nxt      = 3'd7;
                  bytes_done_nxt     = done_inc;
                  result.finished    = (done_inc == payload_length_r);
                end else begin
                  bit_index_nxt = bit_index_r - 3'd1;
                end
              end else begin
                result.payload_missing = 1'b1;
              end
            end
          end else begin
            if (bytes_done_r < header_length_r) begin
              assembled_byte_nxt = assembled_byte_r;
              assembled_byte_nxt[bit_index_r] = assembled_byte_r[bit_index_r] | in_data.value[0];
              if (bit_index_r == 3'd0) begin
                result.out_byte    = assembled_byte_nxt;
                assembled_byte_nxt = 8'd0;
                bit_index_nxt      = 3'd7;
                bytes_done_nxt     = done_inc;
                result.finished    = (done_inc == header_length_r);
                emit               = 1'b1;
              end else begin
                bit_index_nxt = bit_index_r - 3'd1;
              end
            end
          end
          // Count the carrier; a width change can leave the count past the row end.
          if (row_inc >= {1'b0, rb_now}) begin
            row_byte_count_nxt = '0;
            padding_left_nxt   = pad_len_r;
          end else begin
            row_byte_count_nxt = row_inc[RowBytesW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_EMBED;
      row_bytes_r      <= row_bytes_f(15'd1);
      pad_len_r        <= 2'(-row_bytes_f(15'd1));
      payload_length_r <= '0;
      file_position_r  <= '0;
      pixel_offset_r   <= '0;
      header_length_r  <= '0;
      row_byte_count_r <= '0;
      padding_left_r   <= '0;
      bit_index_r      <= 3'd7;
      payload_shift_r  <= '0;
      payload_loaded_r <= 1'b0;
      bytes_done_r     <= '0;
      assembled_byte_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:           mode_r <= cfg_data[0];
          CFG_IMAGE_WIDTH: begin
            row_bytes_r <= row_bytes_f(cfg_data[14:0]);
            // Padding is (4 - rb mod 4) mod 4, which is -rb modulo 4.
            pad_len_r   <= 2'(-row_bytes_f(cfg_data[14:0]));
          end
          CFG_PAYLOAD_LENGTH: payload_length_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        file_position_r  <= file_position_nxt;
        pixel_offset_r   <= pixel_offset_nxt;
        header_length_r  <= header_length_nxt;
        row_byte_count_r <= row_byte_count_nxt;
        padding_left_r   <= padding_left_nxt;
        bit_index_r      <= bit_index_nxt;
        payload_shift_r  <= payload_shift_nxt;
        payload_loaded_r <= payload_loaded_nxt;
        bytes_done_r     <= bytes_done_nxt;
        assembled_byte_r <= assembled_byte_nxt;
        out_valid_r      <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= result;
    end
  end

endmodule
`default_nettype wire

// ----- tb/lsb_stego_bmp_embed_extract_top_tb.sv -----
// Testbench for the LSB BMP stego block: streamed file bytes checked against a local predictor.
`timescale 1ns / 1ps
module lsb_stego_bmp_embed_extract_top_tb;
  import lsb_stego_pkg::*;

  typedef struct {
    out_word_t       w;
    longint unsigned stamp;
  } stego_result_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  // Words waiting to be sent and results waiting to arrive.
  in_word_t      stream_q[$];
  stego_result_t result_q[$];

  int err_cnt        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Local copy of the registers and the stream state.
  logic        cfg_mode   = MODE_EMBED;
  logic [14:0] cfg_width  = 15'd1;
  logic [31:0] cfg_plen   = 32'd0;
  logic [31:0] file_pos   = '0;
  logic [31:0] pix_off    = '0;
  logic [31:0] hdr_len    = '0;
  logic [15:0] row_cnt    = '0;
  logic [1:0]  pad_left   = '0;
  logic [2:0]  bit_idx    = 3'd7;
  logic [7:0]  pay_shift  = '0;
  logic        pay_loaded = 1'b0;
  logic [31:0] done_cnt   = '0;
  logic [7:0]  rec_byte   = '0;

  lsb_stego_bmp_embed_extract_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the stream state by one word; returns 1 when the word yields a result.
  function automatic bit embed_extract_step(input in_word_t w, output out_word_t r);
    logic [31:0] pos;
    logic [1:0]  lane;
    logic [15:0] wd;
    logic [15:0] rb;
    bit          emit;
    pos = file_pos;
    r.out_byte        = w.value;
    r.payload_missing = 1'b0;
    r.finished        = 1'b0;
    if (w.command == CMD_PAYLOAD_BYTE) begin
      if (cfg_mode == MODE_EMBED && !pay_loaded && done_cnt < cfg_plen) begin
        pay_shift  = w.value;
        pay_loaded = 1'b1;
        bit_idx    = 3'd7;
      end
      return 1'b0;
    end
    if (file_pos != '1) file_pos++;
    emit = (cfg_mode == MODE_EMBED);
    if (pos >= PosLenFirst && pos <= PosLenLast) begin
      lane = 2'(pos - PosLenFirst);
      hdr_len[lane*8 +: 8] = w.value;
      if (cfg_mode == MODE_EMBED) r.out_byte = cfg_plen[lane*8 +: 8];
    end else if (pos >= PosOffFirst && pos <= PosOffLast) begin
      lane = 2'(pos - PosOffFirst);
      pix_off[lane*8 +: 8] = w.value;
    end else if (pos >= PosPixFirst && pos >= pix_off) begin
      if (pad_left != 2'd0) begin
        pad_left--;
      end else begin
        if (cfg_mode == MODE_EMBED) begin
          if (done_cnt < cfg_plen) begin
            if (pay_loaded) begin
              r.out_byte = (w.value & LsbClearMask) | {7'd0, pay_shift[bit_idx]};
              if (bit_idx == 3'd0) begin
                pay_loaded = 1'b0;
                bit_idx    = 3'd7;
                done_cnt++;
                r.finished = (done_cnt == cfg_plen);
              end else begin
                bit_idx--;
              end
            end else begin
              r.payload_missing = 1'b1;
            end
          end
        end else if (done_cnt < hdr_len) begin
          // OR rather than set: an embed phase may have rewound the bit index.
          rec_byte = rec_byte | (8'(w.value[0]) << bit_idx);
          if (bit_idx == 3'd0) begin
            r.out_byte = rec_byte;
            rec_byte   = '0;
            bit_idx    = 3'd7;
            done_cnt++;
            r.finished = (done_cnt == hdr_len);
            emit       = 1'b1;
          end else begin
            bit_idx--;
          end
        end
        wd = (cfg_width == '0) ? 16'd1 :
             (cfg_width > MaxImageWidth) ? 16'(MaxImageWidth) : 16'(cfg_width);
        rb = 16'(wd * 3);
        row_cnt++;
        if (row_cnt >= rb) begin
          row_cnt  = '0;
          // Pad the row up to a multiple of four bytes.
          pad_left = 2'd0 - rb[1:0];
        end
      end
    end
    return emit;
  endfunction

  function automatic void push_word(input logic c, input logic [7:0] v);
    in_word_t w;
    w.command = c;
    w.value   = v;
    stream_q.push_back(w);
  endfunction

  // Mostly well-formed bursts: a payload byte (embed) followed by a run of
  // carrier bytes; the rest is random noise.
  task automatic add_phase_words(input logic m, input int n);
    int cnt;
    int k;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        if (m == MODE_EMBED) begin
          push_word(CMD_PAYLOAD_BYTE, 8'($urandom));
          cnt++;
        end
        k = $urandom_range(8, 11);
        if (k > n - cnt) k = n - cnt;
        repeat (k) push_word(CMD_FILE_BYTE, 8'($urandom));
        cnt += k;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) push_word(1'($urandom), 8'($urandom));
        cnt += k;
      end
    end
  endtask

  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:           cfg_mode  = data[0];
      CFG_IMAGE_WIDTH:    cfg_width = data[14:0];
      CFG_PAYLOAD_LENGTH: cfg_plen  = data;
      default: ;
    endcase
  endtask

  // Waits until every word is sent and every result is back, then lets the
  // block settle on words that gave no result.
  task automatic wait_idle();
    do @(negedge clk); while (stream_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Driver: predicts each accepted word and presents the next one.
  always @(posedge clk) begin
    stego_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (embed_extract_step(in_data, r.w)) begin
          r.stamp = $time;
          result_q.push_back(r);
        end
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    stego_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0 || result_q[0].stamp >= $time) begin
          $error("result word %0h arrived with none pending", out_data);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (out_data.out_byte !== want.w.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.w.out_byte, out_data.out_byte);
            err_cnt++;
          end
          if (out_data.payload_missing !== want.w.payload_missing) begin
            $error("payload_missing: expected %0b, got %0b",
                   want.w.payload_missing, out_data.payload_missing);
            err_cnt++;
          end
          if (out_data.finished !== want.w.finished) begin
            $error("finished: expected %0b, got %0b", want.w.finished, out_data.finished);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [31:0] hdr;
    logic [31:0] off;
    logic [31:0] wdata;
    logic        m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct  = 23;
    recv_stall_pct = 63;

    // Directed start of the file: header, offset gap, a carrier with no
    // payload waiting, a dropped second payload byte, extreme carrier values.
    cfg_write(CFG_PAYLOAD_LENGTH, 32'd2);
    hdr = $urandom_range(16, 32);
    off = $urandom_range(10, 16);
    push_word(CMD_FILE_BYTE, 8'h42);
    push_word(CMD_FILE_BYTE, 8'h4D);
    push_word(CMD_FILE_BYTE, 8'hFF);
    push_word(CMD_FILE_BYTE, 8'h00);
    push_word(CMD_FILE_BYTE, 8'hFF);
    push_word(CMD_FILE_BYTE, 8'h00);
    for (int i = 0; i < 4; i++) push_word(CMD_FILE_BYTE, hdr[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_word(CMD_FILE_BYTE, off[8*i +: 8]);
    for (int i = 14; i < off; i++) push_word(CMD_FILE_BYTE, 8'($urandom));
    push_word(CMD_FILE_BYTE, 8'hFF);
    push_word(CMD_PAYLOAD_BYTE, 8'hA5);
    push_word(CMD_PAYLOAD_BYTE, 8'h3C);
    for (int i = 0; i < 8; i++) push_word(CMD_FILE_BYTE, i[0] ? 8'hFF : 8'h00);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct  = 63;
        recv_stall_pct = 23;
      end else if (p == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      m = (p % 3 == 1) ? MODE_RECOVER : MODE_EMBED;
      case (p)
        0:       wdata = 32'd0;
        1:       wdata = 32'd2;
        2:       wdata = MaxImageWidth;
        3:       wdata = 32'd3;
        4:       wdata = 32'h0000_7FFF;
        5:       wdata = 32'd4;
        6:       wdata = 32'd1;
        7:       wdata = 32'hFFFF_8005;
        default: wdata = $urandom_range(1, 6);
      endcase
      cfg_write(CFG_MODE, {31'd0, m});
      cfg_write(CFG_IMAGE_WIDTH, wdata);
      if (p == 2) wdata = 32'd0;
      else if (p == 5) wdata = '1;
      else wdata = done_cnt + $urandom_range(2, 6);
      cfg_write(CFG_PAYLOAD_LENGTH, wdata);
      if (p == 6) begin
        // The sender holds back halfway until every result is back.
        add_phase_words(m, 27);
        wait_idle();
        add_phase_words(m, 27);
      end else begin
        add_phase_words(m, 54);
      end
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** lsb_stego_bmp_embed_extract_top: PASSED **");
    end else begin
      $display("** lsb_stego_bmp_embed_extract_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("** lsb_stego_bmp_embed_extract_top: FAILED **");
    $finish;
  end

endmodule
